[hdl/frot_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_pkg: shared types and constants of the frame rotator
// Register map, opcodes, rotation codes and the command passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package frot_pkg;

   localparam int PIXEL_W        = 32;
   localparam int DIM_W          = 9;
   localparam int ROT_W          = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 9;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int CMD_DEPTH      = 4;
   localparam int OUT_DEPTH      = 4;
   localparam int DIM_LIMIT      = 511;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [ROT_W-1:0] {
      ROT_NONE,
      ROT_90,
      ROT_180,
      ROT_270
   } rot_type;

   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_READ,
      CMD_EARLY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         last;
   } cmd_ctrl_type;

   function automatic int bits_for(input int n);
      return (n <= 1) ? 1 : $clog2(n);
   endfunction

endpackage

[hdl/frot_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_req_if: request channel of the frame rotator
// Valid/ready channel carrying one store or read request.
// ----------------------------------------------------------------------------
interface frot_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] pixel_in;

   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

[hdl/frot_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_rsp_if: response channel of the frame rotator
// Valid/ready channel carrying one rotated pixel and its flags.
// ----------------------------------------------------------------------------
interface frot_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_out;
   logic        last_of_frame;
   logic        frame_ready;

   modport source (output valid, output pixel_out, output last_of_frame,
                   output frame_ready, input ready);
   modport sink   (input valid, input pixel_out, input last_of_frame,
                   input frame_ready, output ready);
endinterface

[hdl/frot_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module frot_ram import frot_pkg::*; #(
   parameter int WIDTH = PIXEL_W,
   parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
   localparam int ADDR_W = bits_for(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/frot_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_fifo: small synchronous queue
// Register-based FIFO with valid/ready on both sides and an occupancy count.
// ----------------------------------------------------------------------------
module frot_fifo import frot_pkg::*; #(
   parameter int WIDTH = PIXEL_W,
   parameter int DEPTH = CMD_DEPTH,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data,
   output logic [CNT_W-1:0] count
);

   localparam int PTR_W = bits_for(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/frot_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_front: request front end of the frame rotator
// Holds the geometry registers and the store/read raster positions, and
// turns each request into a memory command with its address.
// ----------------------------------------------------------------------------
module frot_front import frot_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int ADDR_W = bits_for(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   frot_req_if.sink               req,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output cmd_ctrl_type           cmd_ctrl,
   output logic [ADDR_W-1:0]      cmd_addr,
   output logic [PIXEL_W-1:0]     cmd_data
);

   localparam int W_LIM = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
   localparam int H_LIM = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
   localparam int COL_W = bits_for(W_LIM);
   localparam int ROW_W = bits_for(H_LIM);
   localparam int RD_W  = (COL_W > ROW_W) ? COL_W : ROW_W;

   rot_type          rotation_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;

   logic [COL_W-1:0] wr_col_ff, wr_col_in;
   logic [ROW_W-1:0] wr_row_ff, wr_row_in;
   logic [RD_W-1:0]  rd_col_ff, rd_col_in;
   logic [RD_W-1:0]  rd_row_ff, rd_row_in;
   logic             ready_ff, ready_in;

   logic [DIM_W-1:0]  sw, sh, sw_m1, sh_m1;
   logic [DIM_W-1:0]  dw_m1, dh_m1;
   logic [DIM_W-1:0]  rc, rr, sx, sy;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              swap;
   logic              rd_last;
   logic              accept;
   logic              clear;

   // dimension registers clamp to 1..limit
   always_comb begin
      if (width_ff == '0) begin
         sw = DIM_W'(1);
      end else if (width_ff > DIM_W'(W_LIM)) begin
         sw = DIM_W'(W_LIM);
      end else begin
         sw = width_ff;
      end
      if (height_ff == '0) begin
         sh = DIM_W'(1);
      end else if (height_ff > DIM_W'(H_LIM)) begin
         sh = DIM_W'(H_LIM);
      end else begin
         sh = height_ff;
      end
   end

   assign sw_m1 = sw - DIM_W'(1);
   assign sh_m1 = sh - DIM_W'(1);
   assign swap  = (rotation_ff == ROT_90) || (rotation_ff == ROT_270);
   assign dw_m1 = swap ? sh_m1 : sw_m1;
   assign dh_m1 = swap ? sw_m1 : sh_m1;
   assign rc    = DIM_W'(rd_col_ff);
   assign rr    = DIM_W'(rd_row_ff);

   // destination raster position back to source coordinates
   always_comb begin
      case (rotation_ff)
         ROT_90: begin
            sx = rr;
            sy = sh_m1 - rc;
         end
         ROT_180: begin
            sx = sw_m1 - rc;
            sy = sh_m1 - rr;
         end
         ROT_270: begin
            sx = sw_m1 - rr;
            sy = rc;
         end
         default: begin
            sx = rc;
            sy = rr;
         end
      endcase
   end

   assign wr_addr = ADDR_W'(wr_row_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(wr_col_ff);
   assign rd_addr = ADDR_W'(sy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx);
   assign rd_last = (rc == dw_m1) && (rr == dh_m1);

   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;
   assign accept    = req.valid && cmd_ready;
   assign clear     = csr_we && ((csr_index == CSR_ROTATION) ||
                                 (csr_index == CSR_FRAME_WIDTH) ||
                                 (csr_index == CSR_FRAME_HEIGHT));

   always_comb begin
      cmd_data = req.pixel_in;
      if (req.opcode == OP_STORE) begin
         cmd_ctrl.kind = CMD_STORE;
         cmd_ctrl.last = 1'b0;
         cmd_addr      = wr_addr;
      end else if (ready_ff) begin
         cmd_ctrl.kind = CMD_READ;
         cmd_ctrl.last = rd_last;
         cmd_addr      = rd_addr;
      end else begin
         cmd_ctrl.kind = CMD_EARLY;
         cmd_ctrl.last = 1'b0;
         cmd_addr      = rd_addr;
      end
   end

   always_comb begin
      wr_col_in = wr_col_ff;
      wr_row_in = wr_row_ff;
      rd_col_in = rd_col_ff;
      rd_row_in = rd_row_ff;
      ready_in  = ready_ff;
      if (clear) begin
         wr_col_in = '0;
         wr_row_in = '0;
         rd_col_in = '0;
         rd_row_in = '0;
         ready_in  = 1'b0;
      end else if (accept && (req.opcode == OP_STORE)) begin
         if (DIM_W'(wr_col_ff) == sw_m1) begin
            wr_col_in = '0;
            if (DIM_W'(wr_row_ff) == sh_m1) begin
               wr_row_in = '0;
               ready_in  = 1'b1;
            end else begin
               wr_row_in = wr_row_ff + ROW_W'(1);
            end
         end else begin
            wr_col_in = wr_col_ff + COL_W'(1);
         end
      end else if (accept && ready_ff) begin
         if (rc == dw_m1) begin
            rd_col_in = '0;
            rd_row_in = (rr == dh_m1) ? '0 : rd_row_ff + RD_W'(1);
         end else begin
            rd_col_in = rd_col_ff + RD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= ROT_NONE;
         width_ff    <= DIM_RESET;
         height_ff   <= DIM_RESET;
         wr_col_ff   <= '0;
         wr_row_ff   <= '0;
         rd_col_ff   <= '0;
         rd_row_ff   <= '0;
         ready_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROTATION:     rotation_ff <= rot_type'(csr_wdata[ROT_W-1:0]);
               CSR_FRAME_WIDTH:  width_ff    <= csr_wdata[DIM_W-1:0];
               CSR_FRAME_HEIGHT: height_ff   <= csr_wdata[DIM_W-1:0];
               default: begin
               end
            endcase
         end
         wr_col_ff <= wr_col_in;
         wr_row_ff <= wr_row_in;
         rd_col_ff <= rd_col_in;
         rd_row_ff <= rd_row_in;
         ready_ff  <= ready_in;
      end
   end

endmodule

[hdl/frot_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_back: memory back end of the frame rotator
// Executes queued commands on the frame store and buffers read results in
// an output queue that decouples the response channel.
// ----------------------------------------------------------------------------
module frot_back import frot_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int ADDR_W = bits_for(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  cmd_ctrl_type       cmd_ctrl,
   input  logic [ADDR_W-1:0]  cmd_addr,
   input  logic [PIXEL_W-1:0] cmd_data,
   frot_rsp_if.source         rsp
);

   localparam int OUT_W   = PIXEL_W + 2;
   localparam int OCNT_W  = $clog2(OUT_DEPTH + 1);
   localparam int CRED_W  = OCNT_W + 1;

   logic               pend_ff, pend_in;
   logic               pend_ready_ff, pend_ready_in;
   logic               pend_last_ff, pend_last_in;
   logic [PIXEL_W-1:0] ram_rd_data;
   logic [OCNT_W-1:0]  out_count;
   logic [OUT_W-1:0]   out_push_data;
   logic [OUT_W-1:0]   out_pop_data;
   logic               is_store;
   logic               credit_ok;
   logic               pop;

   assign is_store  = (cmd_ctrl.kind == CMD_STORE);
   // reserve an output slot for every read still in the memory pipe
   assign credit_ok = (CRED_W'(out_count) + CRED_W'(pend_ff)) < CRED_W'(OUT_DEPTH);
   assign cmd_ready = is_store || credit_ok;
   assign pop       = cmd_valid && cmd_ready;

   assign pend_in       = pop && !is_store;
   assign pend_ready_in = (cmd_ctrl.kind == CMD_READ);
   assign pend_last_in  = cmd_ctrl.last;

   frot_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_store (
      .clock   (clock),
      .wr_en   (pop && is_store),
      .wr_addr (cmd_addr),
      .wr_data (cmd_data),
      .rd_en   (pop && (cmd_ctrl.kind == CMD_READ)),
      .rd_addr (cmd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_in) begin
         pend_ready_ff <= pend_ready_in;
         pend_last_ff  <= pend_last_in;
      end
   end

   assign out_push_data = {(pend_ready_ff ? ram_rd_data : PIXEL_W'(0)),
                           pend_last_ff, pend_ready_ff};

   frot_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (pend_ff),
      .push_ready (),
      .push_data  (out_push_data),
      .pop_valid  (rsp.valid),
      .pop_ready  (rsp.ready),
      .pop_data   (out_pop_data),
      .count      (out_count)
   );

   assign rsp.pixel_out     = out_pop_data[OUT_W-1:2];
   assign rsp.last_of_frame = out_pop_data[1];
   assign rsp.frame_ready   = out_pop_data[0];

endmodule

[hdl/frame_rotate_90_180_270_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rotate_90_180_270_unit: frame rotator for packed BGRA pixels
// Stores a source frame in raster order and reads it back rotated by
// 0, 90, 180 or 270 degrees clockwise.
// ----------------------------------------------------------------------------
//  channel | dir | transfer when        | payload
//  --------+-----+----------------------+-----------------------------------
//  req_bus | in  | valid && ready       | opcode, pixel_in
//  rsp_bus | out | valid && ready       | pixel_out, last_of_frame, frame_ready
//  csr_*   | in  | csr_we               | csr_index, csr_wdata
//
//  One request per clock sustained while no response stall backs up the queues;
//  a store or a read of a stored frame costs one frame-store port access. A read
//  result passes through the command queue, the registered memory read and the
//  output queue before it can transfer on rsp_bus.
//  Reset clears control state only; the frame store has no clearing pass.
//  Response stalls fill the 4-entry output queue, then the back end stops
//  issuing reads, the 4-entry command queue fills and req_bus.ready drops.
// ----------------------------------------------------------------------------
module frame_rotate_90_180_270_unit import frot_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   frot_req_if.sink               req_bus,
   frot_rsp_if.source             rsp_bus
);

   localparam int ADDR_W = bits_for(MAX_WIDTH * MAX_HEIGHT);
   localparam int CTRL_W = $bits(cmd_ctrl_type);
   localparam int CMD_W  = CTRL_W + ADDR_W + PIXEL_W;

   logic               fe_valid, fe_ready;
   cmd_ctrl_type       fe_ctrl;
   logic [ADDR_W-1:0]  fe_addr;
   logic [PIXEL_W-1:0] fe_data;

   logic               be_valid, be_ready;
   cmd_ctrl_type       be_ctrl;
   logic [ADDR_W-1:0]  be_addr;
   logic [PIXEL_W-1:0] be_data;
   logic [CMD_W-1:0]   q_pop_data;

   frot_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .cmd_valid (fe_valid),
      .cmd_ready (fe_ready),
      .cmd_ctrl  (fe_ctrl),
      .cmd_addr  (fe_addr),
      .cmd_data  (fe_data)
   );

   frot_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_data  ({fe_ctrl, fe_addr, fe_data}),
      .pop_valid  (be_valid),
      .pop_ready  (be_ready),
      .pop_data   (q_pop_data),
      .count      ()
   );

   assign be_ctrl = cmd_ctrl_type'(q_pop_data[CMD_W-1 -: CTRL_W]);
   assign be_addr = q_pop_data[PIXEL_W +: ADDR_W];
   assign be_data = q_pop_data[PIXEL_W-1:0];

   frot_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (be_valid),
      .cmd_ready (be_ready),
      .cmd_ctrl  (be_ctrl),
      .cmd_addr  (be_addr),
      .cmd_data  (be_data),
      .rsp       (rsp_bus)
   );

endmodule

[hdl/frot_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frot_checker: port-level checks of the frame rotator
// Watches the response channel for flag consistency, hold under stall and
// the minimum result latency after reset.
// ----------------------------------------------------------------------------
module frot_checker import frot_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] rsp_pixel,
   input logic               rsp_last,
   input logic               rsp_frame_ready
);

   // end of frame only exists for a stored frame
   a_last_needs_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_frame_ready)
      else $error("last_of_frame without frame_ready");

   // a read before the frame is stored answers all zero
   a_early_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ready |-> (rsp_pixel == '0) && !rsp_last)
      else $error("early read returned nonzero data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) &&
                                  $stable(rsp_last) && $stable(rsp_frame_ready))
      else $error("stalled response changed");

   // command queue, memory read and output queue keep results off the channel just after reset
   a_reset_latency: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response too soon after reset");

endmodule

bind frame_rotate_90_180_270_unit frot_checker u_frot_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_pixel       (rsp_bus.pixel_out),
   .rsp_last        (rsp_bus.last_of_frame),
   .rsp_frame_ready (rsp_bus.frame_ready)
);
